[src/lrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared widths and command codes of the line raster frame buffer.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int COUNT_W = 13;

  // Largest count a single draw can reach: one pixel per major-axis column.
  localparam int MAX_PIXELS = 4096;

  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [COUNT_W-1:0]        count_t;

endpackage

[src/lrf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_ram
// Single-port synchronous RAM with one registered read per cycle.
// ----------------------------------------------------------------------------
module lrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[src/line_raster_framebuffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_framebuffer
// RGB565 frame store with a Bresenham line rasterizer and a pixel read port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command beat: a draw
//   (func 0) of the line from start to end in pen_color, or a read (func 1)
//   of the pixel at start. One command is worked on at a time; in_stall_o is
//   high while the block is busy.
//   Output channel (out_valid_o / out_stall_i) returns one result beat per
//   command: pixel_value for a read (zero off screen), pixels_drawn for a draw.
//   A draw steps through S_SETUP1 and S_SETUP2 into S_DRAW, the rasterizer
//   writing one pixel per cycle along the major axis through
//   the single RAM port; a read issues the RAM read in S_READ and captures
//   the data in S_RDWAIT. Both end in S_DONE, and the next command is taken
//   while a finished result still waits on a stalled receiver, and the block
//   holds its next result until the output register is free.
//   After reset the frame store is swept to black, one entry per cycle, over
//   all SCREEN_WIDTH * SCREEN_HEIGHT entries (65536 at the defaults); no
//   command is accepted during the sweep.
//   A stalled result beat holds its payload until taken.
// ----------------------------------------------------------------------------
module line_raster_framebuffer #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            func_i,
  input  lrf_pkg::coord_t start_x_i,
  input  lrf_pkg::coord_t start_y_i,
  input  lrf_pkg::coord_t end_x_i,
  input  lrf_pkg::coord_t end_y_i,
  input  lrf_pkg::color_t pen_color_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lrf_pkg::color_t pixel_value_o,
  output lrf_pkg::count_t pixels_drawn_o
);

  import lrf_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = 22;  // linear address before truncation to AW
  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [COORD_W-1:0]   W_LIM     = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0]   H_LIM     = COORD_W'(SCREEN_HEIGHT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP1 = 3'd2;
  localparam logic [2:0] S_SETUP2 = 3'd3;
  localparam logic [2:0] S_DRAW   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  function automatic logic on_screen(coord_t x, coord_t y);
    on_screen = !x[COORD_W-1] && !y[COORD_W-1] &&
                ({1'b0, x[COORD_W-2:0]} < W_LIM) && ({1'b0, y[COORD_W-2:0]} < H_LIM);
  endfunction

  function automatic logic [AW-1:0] lin_addr(coord_t x, coord_t y);
    logic [LW-1:0] lin;
    lin = LW'(y[COORD_W-2:0]) * LW'(SCREEN_WIDTH) + LW'(x[COORD_W-2:0]);
    lin_addr = lin[AW-1:0];
  endfunction

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;

  // Command registers
  coord_t          sx_q, sy_q, ex_q, ey_q;
  color_t          color_q;

  // Rasterizer registers
  logic            steep_q;
  coord_t          au_q, av_q, bu_q, bv_q;
  logic [COORD_W-1:0] dmaj_q, dmin_q;
  logic signed [COORD_W+1:0] err_q;
  logic            up_q;
  coord_t          u_q, v_q;
  count_t          count_q;

  logic            rd_on_q;
  color_t          res_pix_q;
  count_t          res_cnt_q;

  logic            out_valid_q;
  color_t          out_pix_q;
  count_t          out_cnt_q;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  color_t          ram_wdata;
  color_t          ram_rdata;

  lrf_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic            in_acc;
  logic            out_free;
  coord_t          px, py;
  logic            pix_on;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic            steep;
  logic signed [COORD_W+1:0] err_sub;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign px     = steep_q ? v_q : u_q;
  assign py     = steep_q ? u_q : v_q;
  assign pix_on = on_screen(px, py);

  assign dx    = (COORD_W+1)'(ex_q) - (COORD_W+1)'(sx_q);
  assign dy    = (COORD_W+1)'(ey_q) - (COORD_W+1)'(sy_q);
  assign adx   = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
  assign ady   = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
  assign steep = ady > adx;

  assign err_sub = err_q - (COORD_W+2)'(dmin_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = lin_addr(sx_q, sy_q);
    ram_wdata = color_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      S_DRAW: begin
        ram_we   = pix_on;
        ram_addr = lin_addr(px, py);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (func_i == FUNC_READ) ? S_READ : S_SETUP1;
        end
      end
      S_SETUP1: state_d = S_SETUP2;
      S_SETUP2: state_d = S_DRAW;
      S_DRAW: begin
        if (u_q == bu_q) begin
          state_d = S_DONE;
        end
      end
      S_READ:   state_d = S_RDWAIT;
      S_RDWAIT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
      color_q <= pen_color_i;
    end
    case (state_q)
      S_SETUP1: begin
        // Swap axes for steep lines; deltas do not depend on endpoint order.
        steep_q <= steep;
        au_q    <= steep ? sy_q : sx_q;
        av_q    <= steep ? sx_q : sy_q;
        bu_q    <= steep ? ey_q : ex_q;
        bv_q    <= steep ? ex_q : ey_q;
        dmaj_q  <= steep ? ady : adx;
        dmin_q  <= steep ? adx : ady;
      end
      S_SETUP2: begin
        // Order endpoints along the major axis.
        if (au_q > bu_q) begin
          u_q  <= bu_q;
          v_q  <= bv_q;
          bu_q <= au_q;
          up_q <= bv_q < av_q;
        end else begin
          u_q  <= au_q;
          v_q  <= av_q;
          up_q <= av_q < bv_q;
        end
        err_q   <= (COORD_W+2)'(dmaj_q >> 1);
        count_q <= '0;
      end
      S_DRAW: begin
        u_q <= u_q + 1'b1;
        if (err_sub < 0) begin
          v_q   <= up_q ? v_q + 1'b1 : v_q - 1'b1;
          err_q <= err_sub + (COORD_W+2)'(dmaj_q);
        end else begin
          err_q <= err_sub;
        end
        if (u_q == bu_q) begin
          res_pix_q <= '0;
          res_cnt_q <= count_q + count_t'(pix_on);
        end
        count_q <= count_q + count_t'(pix_on);
      end
      S_READ: begin
        rd_on_q <= on_screen(sx_q, sy_q);
      end
      S_RDWAIT: begin
        res_pix_q <= rd_on_q ? ram_rdata : '0;
        res_cnt_q <= '0;
      end
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      out_pix_q <= res_pix_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_pix_q;
  assign pixels_drawn_o = out_cnt_q;

endmodule

[src/lrf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_checker
// Port-level assertions for the line raster frame buffer.
// ----------------------------------------------------------------------------
module lrf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input lrf_pkg::color_t pixel_value_o,
  input lrf_pkg::count_t pixels_drawn_o
);

  import lrf_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(pixels_drawn_o))
    else $error("stalled result beat changed");

  // A result is either a read or a draw, never both.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_value_o == '0) || (pixels_drawn_o == '0))
    else $error("result carries both pixel value and count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixels_drawn_o <= count_t'(MAX_PIXELS)))
    else $error("pixel count exceeds one per major-axis column");

  // Only one command in flight: busy right after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted while another is in flight");

endmodule

bind line_raster_framebuffer lrf_checker u_lrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_value_o  (pixel_value_o),
  .pixels_drawn_o (pixels_drawn_o)
);

[verif/line_raster_framebuffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_framebuffer_tb
// Self-checking bench for the line raster frame buffer. A shadow frame store
// rasterizes every accepted draw and answers every accepted read; each result
// beat is compared field by field with the oldest outcome still owed. Traffic
// is a short directed set followed by mostly screen-sized random lines mixed
// with reads, under bursty sending and a changing receiver stall pattern.
// ----------------------------------------------------------------------------
module line_raster_framebuffer_tb;
  import lrf_pkg::*;

  localparam int SCREEN_W     = 256;
  localparam int SCREEN_H     = 256;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_EVERY  = 337;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_e;

  typedef struct packed {
    color_t pixel;
    count_t drawn;
  } outcome_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  logic   func      = FUNC_DRAW;
  coord_t start_x   = '0;
  coord_t start_y   = '0;
  coord_t end_x     = '0;
  coord_t end_y     = '0;
  color_t pen_color = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  color_t pixel_value;
  count_t pixels_drawn;

  color_t      shadow_fb [SCREEN_W*SCREEN_H];
  outcome_t    owed_outcomes [$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  bit          sender_live = 1'b0;
  int          trail_x     = 0;
  int          trail_y     = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int          stall_hold  = 0;
  int unsigned stall_tick  = 0;

  line_raster_framebuffer #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .end_x_i        (end_x),
    .end_y_i        (end_y),
    .pen_color_i    (pen_color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_value_o  (pixel_value),
    .pixels_drawn_o (pixels_drawn)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow frame store
  // --------------------------------------------------------------------------
  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit on_screen(int x, int y);
    return (x >= 0) && (x < SCREEN_W) && (y >= 0) && (y < SCREEN_H);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic color_t fetch_pixel(int x, int y);
    if (!on_screen(x, y)) return '0;
    return shadow_fb[y*SCREEN_W + x];
  endfunction

  // Bresenham over the major axis; returns the pixels that landed on screen.
  function automatic int rasterize_line(int ax, int ay, int bx, int by, color_t c);
    bit steep;
    int t, dmaj, dmin, err, stp, u, v, px, py, n;
    n = 0;
    steep = iabs(by - ay) > iabs(bx - ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dmaj = bx - ax;
    dmin = iabs(by - ay);
    err  = dmaj / 2;
    stp  = (ay < by) ? 1 : -1;
    v    = ay;
    for (u = ax; u <= bx; u++) begin
      px = steep ? v : u;
      py = steep ? u : v;
      if (on_screen(px, py)) begin
        shadow_fb[py*SCREEN_W + px] = c;
        n++;
      end
      err -= dmin;
      if (err < 0) begin
        v   += stp;
        err += dmaj;
      end
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic drop_valid();
    if (sender_live) begin
      in_valid    <= 1'b0;
      sender_live  = 1'b0;
    end
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 6);
    end
  endtask

  task automatic send_cmd(logic f, int sx, int sy, int ex, int ey, color_t c);
    coord_t   csx, csy, cex, cey;
    outcome_t o;
    csx = coord_t'(sx);
    csy = coord_t'(sy);
    cex = coord_t'(ex);
    cey = coord_t'(ey);
    func        <= f;
    start_x     <= csx;
    start_y     <= csy;
    end_x       <= cex;
    end_y       <= cey;
    pen_color   <= c;
    in_valid    <= 1'b1;
    sender_live  = 1'b1;
    do @(posedge clk); while (in_stall);
    if (f == FUNC_READ) begin
      o.pixel = fetch_pixel(int'(csx), int'(csy));
      o.drawn = '0;
    end else begin
      o.pixel = '0;
      o.drawn = count_t'(rasterize_line(int'(csx), int'(csy), int'(cex), int'(cey), c));
      if (on_screen(int'(csx), int'(csy))) begin
        trail_x = int'(csx);
        trail_y = int'(csy);
      end
    end
    owed_outcomes.push_back(o);
    pace_sender();
  endtask

  task automatic wait_drained();
    drop_valid();
    while (owed_outcomes.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(50, 400);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_tick[3];
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
               want, got);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_outcomes.size() == 0) begin
        flag_mismatch("unexpected result beat", 0, 32'({pixel_value, pixels_drawn}));
      end else begin
        want = owed_outcomes.pop_front();
        if (pixel_value !== want.pixel)
          flag_mismatch("pixel_value", 32'(want.pixel), 32'(pixel_value));
        if (pixels_drawn !== want.drawn)
          flag_mismatch("pixels_drawn", 32'(want.drawn), 32'(pixels_drawn));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_state();
    send_cmd(FUNC_READ, 0, 0, 0, 0, 16'h1234);
    send_cmd(FUNC_READ, SCREEN_W-1, SCREEN_H-1, -2048, 2047, 16'hFFFF);
    send_cmd(FUNC_READ, -1, 5, 2047, -2048, 16'h0000);
  endtask

  task automatic test_directed_lines();
    send_cmd(FUNC_DRAW, 0, 10, SCREEN_W-1, 10, 16'hFFFF);
    send_cmd(FUNC_DRAW, 20, SCREEN_H-1, 20, 0, 16'h0001);
    send_cmd(FUNC_DRAW, 0, 0, SCREEN_W-1, SCREEN_H-1, 16'hF800);
    send_cmd(FUNC_DRAW, 100, 0, 110, 200, 16'h07E0);
    send_cmd(FUNC_DRAW, 250, 50, 3, 60, 16'h001F);
    // Degenerate line on screen, then off screen.
    send_cmd(FUNC_DRAW, 128, 128, 128, 128, 16'hA5A5);
    send_cmd(FUNC_DRAW, 300, -5, 300, -5, 16'hFFFF);
    send_cmd(FUNC_DRAW, -100, -100, -10, -50, 16'h1111);
    // Extreme endpoints, clipped down to the visible part.
    send_cmd(FUNC_DRAW, -2048, -2048, 2047, 2047, 16'h5A5A);
    send_cmd(FUNC_DRAW, -2048, 300, 2047, -20, 16'h0000);
    send_cmd(FUNC_READ, 0, 10, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, 20, 0, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, 128, 128, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, SCREEN_W-1, SCREEN_H-1, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, 105, 100, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, 2047, -2048, 0, 0, 16'h0000);
    send_cmd(FUNC_READ, -2048, 2047, 0, 0, 16'h0000);
  endtask

  task automatic test_random_traffic(int count);
    int kind, pick, sx, sy, ex, ey;
    color_t c;
    for (int i = 0; i < count; i++) begin
      // Hold off now and then until every owed result has come back.
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
      kind = $urandom_range(0, 99);
      c    = color_t'($urandom);
      ex   = int'(coord_t'($urandom));
      ey   = int'(coord_t'($urandom));
      if (kind < 45) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
          sx = trail_x;
          sy = trail_y;
        end else if (pick == 2) begin
          sx = $urandom_range(0, SCREEN_W-1);
          sy = $urandom_range(0, SCREEN_H-1);
        end else begin
          sx = int'(coord_t'($urandom));
          sy = int'(coord_t'($urandom));
        end
        send_cmd(FUNC_READ, sx, sy, ex, ey, c);
      end else begin
        if (kind < 75) begin
          sx = int'($urandom_range(0, SCREEN_W+31)) - 16;
          sy = int'($urandom_range(0, SCREEN_H+31)) - 16;
          ex = int'($urandom_range(0, SCREEN_W+31)) - 16;
          ey = int'($urandom_range(0, SCREEN_H+31)) - 16;
        end else if (kind < 88) begin
          sx = $urandom_range(0, SCREEN_W-1);
          sy = $urandom_range(0, SCREEN_H-1);
          ex = sx + int'($urandom_range(0, 16)) - 8;
          ey = sy + int'($urandom_range(0, 16)) - 8;
        end else if (kind < 94) begin
          sx = $urandom_range(0, SCREEN_W-1);
          sy = $urandom_range(0, SCREEN_H-1);
          pick = $urandom_range(0, 2);
          ex = (pick == 1) ? sx : int'($urandom_range(0, SCREEN_W-1));
          ey = (pick == 2) ? sy : int'($urandom_range(0, SCREEN_H-1));
          if (pick == 0) begin
            ex = sx;
            ey = sy;
          end
        end else if (kind < 98) begin
          sx = int'(coord_t'($urandom));
          sy = int'(coord_t'($urandom));
          ex = clamp_coord(sx + int'($urandom_range(0, 40)) - 20);
          ey = clamp_coord(sy + int'($urandom_range(0, 40)) - 20);
        end else begin
          sx = int'(coord_t'($urandom));
          sy = int'(coord_t'($urandom));
        end
        send_cmd(FUNC_DRAW, sx, sy, ex, ey, c);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SCREEN_W*SCREEN_H; i++) shadow_fb[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_lines();
    wait_drained();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
